### hdl/ffba_pkg.sv
// ffba_pkg: shared types, codes and constants of the first-fit block allocator.
// Depends on nothing; used by ffba_table, ffba_seq and first_fit_block_allocator_top.
`default_nettype none

package ffba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 64;
    localparam int unsigned HDR_BYTES      = 24;
    localparam int unsigned HEAP_MAX       = 1048576;
    localparam int unsigned OFS_W          = 20;
    localparam int unsigned LEN_W          = 21;
    localparam int unsigned NEED_W         = 22;
    localparam int unsigned ST_W           = 2;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_UNKNOWN    = 2'd3
    } t_status;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic             in_use;
    } t_entry;

    typedef struct packed {
        logic [OFS_W-1:0] offset;
        t_status          status;
    } t_result;

endpackage

`default_nettype wire

### hdl/ffba_table.sv
// ffba_table: block table memory, one write port and one registered read port.
// Depends on ffba_pkg for the entry type.
`default_nettype none

module ffba_table #(
    parameter int unsigned DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output ffba_pkg::t_entry     o_rd_data,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  ffba_pkg::t_entry     i_wr_data
);

    ffba_pkg::t_entry r_mem [DEPTH];
    ffba_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/ffba_seq.sv
// ffba_seq: request sequencer with the shared entry compare unit, block count and break.
// Depends on ffba_pkg; drives the ports of ffba_table.
`default_nettype none

module ffba_seq #(
    parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned AW         = $clog2(MAX_BLOCKS),
    parameter int unsigned CW         = $clog2(MAX_BLOCKS + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic                          i_op,
    input  wire logic [ffba_pkg::LEN_W-1:0]    i_req_size,
    input  wire logic [ffba_pkg::OFS_W-1:0]    i_free_offset,
    input  wire logic [ffba_pkg::LEN_W-1:0]    i_heap_bytes,
    output logic                               o_res_valid,
    input  wire logic                          i_res_take,
    output ffba_pkg::t_result                  o_res,
    output logic                               o_rd_en,
    output logic [AW-1:0]                      o_rd_addr,
    input  ffba_pkg::t_entry                   i_rd_data,
    output logic                               o_wr_en,
    output logic [AW-1:0]                      o_wr_addr,
    output ffba_pkg::t_entry                   o_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam int unsigned NW = ffba_pkg::NEED_W;
    localparam logic [NW-1:0] ALIGN_ADD = NW'(7);
    localparam logic [NW-1:0] ALIGN_MSK = ~NW'(7);
    localparam logic [NW-1:0] HDR       = NW'(ffba_pkg::HDR_BYTES);
    localparam logic [ffba_pkg::LEN_W-1:0] HMAX = ffba_pkg::LEN_W'(ffba_pkg::HEAP_MAX);
    localparam logic [CW-1:0] FULL      = CW'(MAX_BLOCKS);

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [ffba_pkg::LEN_W-1:0]   r_break, n_break;
    ffba_pkg::t_op                r_op, n_op;
    logic [NW-1:0]                r_need, n_need;
    logic [NW-1:0]                r_pay, n_pay;
    logic [ffba_pkg::OFS_W-1:0]   r_off, n_off;
    logic [CW-1:0]                r_rd_idx, n_rd_idx;
    logic                         r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]                r_cmp_idx, n_cmp_idx;
    ffba_pkg::t_result            r_res, n_res;

    logic                         issue;
    logic                         hit;
    logic [ffba_pkg::LEN_W-1:0]   limit;
    logic [NW:0]                  carve_end;

    always_comb begin
        limit     = (i_heap_bytes > HMAX) ? HMAX : i_heap_bytes;
        carve_end = {1'b0, r_pay} + {1'b0, r_need};
        issue     = r_rd_idx < r_count;
        if (r_op == ffba_pkg::OP_ALLOC) begin
            hit = r_cmp_vld && !i_rd_data.in_use
                  && ({1'b0, i_rd_data.length} >= r_need);
        end else begin
            hit = r_cmp_vld && (i_rd_data.start == r_off);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_break   = r_break;
        n_op      = r_op;
        n_need    = r_need;
        n_pay     = r_pay;
        n_off     = r_off;
        n_rd_idx  = r_rd_idx;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        o_rd_addr = r_rd_idx[AW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_cmp_idx;
        o_wr_data = i_rd_data;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op      = ffba_pkg::t_op'(i_op);
                    n_need    = ({1'b0, i_req_size} + ALIGN_ADD) & ALIGN_MSK;
                    n_pay     = {1'b0, r_break} + HDR;
                    n_off     = i_free_offset;
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    o_wr_en          = 1'b1;
                    o_wr_addr        = r_cmp_idx;
                    o_wr_data.in_use = (r_op == ffba_pkg::OP_ALLOC);
                    n_res.status     = ffba_pkg::ST_OK;
                    n_res.offset     = (r_op == ffba_pkg::OP_ALLOC) ? i_rd_data.start : '0;
                    n_cmp_vld        = 1'b0;
                    n_state          = S_DONE;
                end else if (issue) begin
                    o_rd_en   = 1'b1;
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[AW-1:0];
                end else if (r_cmp_vld) begin
                    n_cmp_vld = 1'b0;
                end else begin
                    n_state      = S_DONE;
                    n_res.offset = '0;
                    if (r_op == ffba_pkg::OP_FREE) begin
                        n_res.status = ffba_pkg::ST_UNKNOWN;
                    end else if (r_count == FULL) begin
                        n_res.status = ffba_pkg::ST_TABLE_FULL;
                    end else if ((carve_end > {2'b00, limit}) || (r_pay[NW-1:ffba_pkg::OFS_W] != '0)) begin
                        n_res.status = ffba_pkg::ST_EXHAUSTED;
                    end else begin
                        o_wr_en          = 1'b1;
                        o_wr_addr        = r_count[AW-1:0];
                        o_wr_data.start  = r_pay[ffba_pkg::OFS_W-1:0];
                        o_wr_data.length = r_need[ffba_pkg::LEN_W-1:0];
                        o_wr_data.in_use = 1'b1;
                        n_count          = r_count + CW'(1);
                        n_break          = carve_end[ffba_pkg::LEN_W-1:0];
                        n_res.status     = ffba_pkg::ST_OK;
                        n_res.offset     = r_pay[ffba_pkg::OFS_W-1:0];
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_break   <= ffba_pkg::LEN_W'(ffba_pkg::HDR_BYTES);
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_break   <= n_break;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_need    <= n_need;
        r_pay     <= n_pay;
        r_off     <= n_off;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

### hdl/first_fit_block_allocator_top.sv
// first_fit_block_allocator_top: heap size register, output register, sequencer and table.
// Depends on ffba_pkg, ffba_table and ffba_seq.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_op, i_req_size, i_free_offset
//  out     | output    | o_out_valid / i_out_stall | o_payload_offset, o_status
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_heap_bytes
//
// From transfer in to a loaded result, the single table read port walks the blocks in
// creation order, one entry a cycle, and stops at the first entry that matches.
// o_in_stall stays high while a request is in the sequencer or its result waits for a
// free output register.
// Synchronous active-low reset: count zero, break 24, heap size 1048576; the table
// itself is not cleared.
`default_nettype none

module first_fit_block_allocator_top #(
    parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_op,
    input  wire logic [ffba_pkg::LEN_W-1:0]  i_req_size,
    input  wire logic [ffba_pkg::OFS_W-1:0]  i_free_offset,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [ffba_pkg::OFS_W-1:0]       o_payload_offset,
    output logic [ffba_pkg::ST_W-1:0]        o_status,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ffba_pkg::LEN_W-1:0]  i_cfg_heap_bytes
);

    localparam int unsigned AW = $clog2(MAX_BLOCKS);

    logic [ffba_pkg::LEN_W-1:0] r_heap_bytes;
    logic                       r_out_valid;
    ffba_pkg::t_result          r_out;

    logic                       req_ready;
    logic                       res_valid;
    logic                       res_take;
    ffba_pkg::t_result          res;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    ffba_pkg::t_entry           rd_data;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    ffba_pkg::t_entry           wr_data;

    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    ffba_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_in_valid),
        .o_req_ready   (req_ready),
        .i_op          (i_op),
        .i_req_size    (i_req_size),
        .i_free_offset (i_free_offset),
        .i_heap_bytes  (r_heap_bytes),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res         (res),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_bytes <= ffba_pkg::LEN_W'(ffba_pkg::HEAP_MAX);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_heap_bytes <= i_cfg_heap_bytes;
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_in_stall       = !req_ready;
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_payload_offset = r_out.offset;
    assign o_status         = r_out.status;

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while previous one in progress");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> (o_out_valid && (o_status == $past(res.status))))
        else $error("result not loaded into output register");

    a_fail_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ffba_pkg::ST_OK)) |-> (o_payload_offset == '0))
        else $error("failed request carries nonzero offset");
`endif

endmodule

`default_nettype wire
